/* src/http_header_line_parser_assert.svh */
// Assertion macros for the HTTP header line parser.
// Needs a clock named clk and an active-high reset named rst in the including scope.
`ifndef HTTP_HEADER_LINE_PARSER_ASSERT_SVH
`define HTTP_HEADER_LINE_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HHLP_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hhlp assertion failed");
`define HHLP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hhlp assertion failed");
`else
`define HHLP_ASSERT_SAME(label, cond, prop)
`define HHLP_ASSERT_NEXT(label, cond, prop)
`endif
`endif

/* src/hhlp_pkg.sv */
// Package for the HTTP header line parser: phase and status codes, byte constants,
// the result struct and the byte class helpers. Depends on nothing.
package hhlp_pkg;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_NAME,
    PH_AFTER_COLON,
    PH_VALUE,
    PH_AFTER_CR,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_MORE,
    ST_DONE,
    ST_ERR
  } status_t;

  localparam int FIELD_BITS = 12;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    status_t               status;
    logic [7:0]            out_byte;
    logic                  empty_line;
    logic [FIELD_BITS-1:0] name_offset;
    logic [FIELD_BITS-1:0] name_length;
    logic [FIELD_BITS-1:0] value_offset;
    logic [FIELD_BITS-1:0] value_length;
  } result_t;

  function automatic logic is_upper(input logic [7:0] c);
    return c inside {[8'h41:8'h5a]};
  endfunction

  function automatic logic is_name_byte(input logic [7:0] c);
    return is_upper(c) || (c inside {[8'h61:8'h7a], [8'h30:8'h39], CH_DASH, CH_UNDER});
  endfunction

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    return is_upper(c) ? (c | 8'h20) : c;
  endfunction

endpackage

/* src/hhlp_step.sv */
// Next-state and result logic of the HTTP header line parser for one byte.
// Depends on hhlp_pkg.
module hhlp_step #(
  parameter int POSITION_BITS = 12
) (
  input  hhlp_pkg::phase_t           phase,
  input  logic [POSITION_BITS-1:0]   line_position,
  input  logic [POSITION_BITS-1:0]   name_start,
  input  logic [POSITION_BITS-1:0]   name_len,
  input  logic [POSITION_BITS-1:0]   value_start,
  input  logic [POSITION_BITS-1:0]   value_len,
  input  logic                       seen_name,
  input  logic [7:0]                 in_byte,
  output hhlp_pkg::phase_t           phase_next,
  output logic [POSITION_BITS-1:0]   line_position_next,
  output logic [POSITION_BITS-1:0]   name_start_next,
  output logic [POSITION_BITS-1:0]   name_len_next,
  output logic [POSITION_BITS-1:0]   value_start_next,
  output logic [POSITION_BITS-1:0]   value_len_next,
  output logic                       seen_name_next,
  output hhlp_pkg::result_t          result
);

  logic             done;
  logic             err;
  logic [7:0]       echo;
  hhlp_pkg::phase_t ph;

  always_comb begin
    ph                 = phase;
    name_start_next    = name_start;
    name_len_next      = name_len;
    value_start_next   = value_start;
    value_len_next     = value_len;
    seen_name_next     = seen_name;
    echo               = in_byte;
    done               = 1'b0;
    err                = 1'b0;
    case (phase)
      hhlp_pkg::PH_LINE_START: begin
        name_start_next  = '0;
        name_len_next    = '0;
        value_start_next = '0;
        value_len_next   = '0;
        seen_name_next   = 1'b0;
        if (hhlp_pkg::is_name_byte(in_byte)) begin
          echo            = hhlp_pkg::lower_byte(in_byte);
          name_start_next = line_position;
          seen_name_next  = 1'b1;
          ph              = hhlp_pkg::PH_NAME;
        end else if (in_byte == hhlp_pkg::CH_CR) begin
          ph = hhlp_pkg::PH_AFTER_CR;
        end else if (in_byte == hhlp_pkg::CH_LF) begin
          done = 1'b1;
        end else if (in_byte != hhlp_pkg::CH_SPACE) begin
          err = 1'b1;
        end
      end
      hhlp_pkg::PH_NAME: begin
        if (hhlp_pkg::is_name_byte(in_byte)) begin
          echo = hhlp_pkg::lower_byte(in_byte);
        end else if (in_byte == hhlp_pkg::CH_COLON) begin
          name_len_next = line_position - name_start;
          ph            = hhlp_pkg::PH_AFTER_COLON;
        end else if (in_byte == hhlp_pkg::CH_CR) begin
          ph = hhlp_pkg::PH_AFTER_CR;
        end else begin
          err = 1'b1;
        end
      end
      hhlp_pkg::PH_AFTER_COLON: begin
        if (in_byte == hhlp_pkg::CH_SPACE) begin
          ph = hhlp_pkg::PH_AFTER_COLON;
        end else if (in_byte == hhlp_pkg::CH_CR) begin
          value_start_next = line_position;
          value_len_next   = '0;
          ph               = hhlp_pkg::PH_AFTER_CR;
        end else if (in_byte == hhlp_pkg::CH_LF) begin
          value_start_next = line_position;
          value_len_next   = '0;
          done             = 1'b1;
        end else begin
          value_start_next = line_position;
          ph               = hhlp_pkg::PH_VALUE;
        end
      end
      hhlp_pkg::PH_VALUE: begin
        if (in_byte == hhlp_pkg::CH_CR) begin
          value_len_next = line_position - value_start;
          ph             = hhlp_pkg::PH_AFTER_CR;
        end else if (in_byte == hhlp_pkg::CH_LF) begin
          value_len_next = line_position - value_start;
          done           = 1'b1;
        end
      end
      hhlp_pkg::PH_AFTER_CR: begin
        if (in_byte == hhlp_pkg::CH_LF) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // The last position the counter holds must finish the line.
    if (!done && !err && (&line_position)) begin
      err = 1'b1;
    end

    result              = '0;
    result.out_byte     = echo;
    line_position_next  = line_position + 1'b1;
    phase_next          = ph;
    if (err) begin
      phase_next         = hhlp_pkg::PH_ERROR;
      line_position_next = line_position;
      result.status      = hhlp_pkg::ST_ERR;
    end else if (done) begin
      phase_next          = hhlp_pkg::PH_LINE_START;
      line_position_next  = '0;
      result.status       = hhlp_pkg::ST_DONE;
      result.empty_line   = !seen_name_next;
      result.name_offset  = hhlp_pkg::FIELD_BITS'(name_start_next);
      result.name_length  = hhlp_pkg::FIELD_BITS'(name_len_next);
      result.value_offset = hhlp_pkg::FIELD_BITS'(value_start_next);
      result.value_length = hhlp_pkg::FIELD_BITS'(value_len_next);
    end else begin
      result.status = hhlp_pkg::ST_MORE;
    end
  end

endmodule

/* src/http_header_line_parser.sv */
// HTTP header line parser: one header byte in, one status item out per byte.
// Depends on hhlp_pkg, hhlp_step and http_header_line_parser_assert.svh.
//
// The block gives one result item per byte, in the cycle after the byte is
// accepted, from a result register. A new byte is taken in every cycle in which
// the result register is empty or its item is being taken, so it takes one byte
// per clock while the output takes every item; the parse state and the result are
// computed from the accepted byte in a single pass of logic. After an error the
// status stays error until reset, and a line that reaches the last position the
// position counter holds without ending gives an error.
module http_header_line_parser #(
  parameter int POSITION_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte [7:0], empty_line [8], name_offset [20:9], name_length [32:21],
  // value_offset [44:33], value_length [56:45], zeros [63:57]
  output logic [63:0] m_tdata,
  output logic [1:0]  m_tuser    // status
);

  `include "http_header_line_parser_assert.svh"

  hhlp_pkg::phase_t         phase;
  hhlp_pkg::phase_t         phase_next;
  logic [POSITION_BITS-1:0] line_position;
  logic [POSITION_BITS-1:0] line_position_next;
  logic [POSITION_BITS-1:0] name_start;
  logic [POSITION_BITS-1:0] name_start_next;
  logic [POSITION_BITS-1:0] name_len;
  logic [POSITION_BITS-1:0] name_len_next;
  logic [POSITION_BITS-1:0] value_start;
  logic [POSITION_BITS-1:0] value_start_next;
  logic [POSITION_BITS-1:0] value_len;
  logic [POSITION_BITS-1:0] value_len_next;
  logic                     seen_name;
  logic                     seen_name_next;
  hhlp_pkg::result_t        result_next;
  hhlp_pkg::result_t        result;
  logic                     accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  hhlp_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .phase              (phase),
    .line_position      (line_position),
    .name_start         (name_start),
    .name_len           (name_len),
    .value_start        (value_start),
    .value_len          (value_len),
    .seen_name          (seen_name),
    .in_byte            (s_tdata),
    .phase_next         (phase_next),
    .line_position_next (line_position_next),
    .name_start_next    (name_start_next),
    .name_len_next      (name_len_next),
    .value_start_next   (value_start_next),
    .value_len_next     (value_len_next),
    .seen_name_next     (seen_name_next),
    .result             (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= hhlp_pkg::PH_LINE_START;
      line_position <= '0;
      name_start    <= '0;
      name_len      <= '0;
      value_start   <= '0;
      value_len     <= '0;
      seen_name     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        line_position <= line_position_next;
        name_start    <= name_start_next;
        name_len      <= name_len_next;
        value_start   <= value_start_next;
        value_len     <= value_len_next;
        seen_name     <= seen_name_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tuser = result.status;
  assign m_tdata = {7'b0, result.value_length, result.value_offset, result.name_length,
                    result.name_offset, result.empty_line, result.out_byte};

  `HHLP_ASSERT_NEXT(a_err_sticks, accept && result_next.status == hhlp_pkg::ST_ERR,
                    phase == hhlp_pkg::PH_ERROR)
  `HHLP_ASSERT_SAME(a_err_state_reports, accept && phase == hhlp_pkg::PH_ERROR,
                    result_next.status == hhlp_pkg::ST_ERR)
  `HHLP_ASSERT_NEXT(a_done_restarts, accept && result_next.status == hhlp_pkg::ST_DONE,
                    line_position == '0 && phase == hhlp_pkg::PH_LINE_START)

endmodule
